FILE: design/afk_pkg.sv
// Shared types, constants and CORDIC tables of the arm forward kinematics block.
// No dependencies; every other design file imports this package.
package afk_pkg;

    localparam int ANG_W     = 16;
    localparam int LEN_W     = 20;
    localparam int POS_W     = 23;
    localparam int PHASE_W   = 33;
    localparam int CS_W      = 33;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH    = 2;

    localparam int DEF_ANGLE_FRAC_BITS = 12;
    localparam int DEF_CORDIC_STAGES   = 16;
    localparam int MIN_STAGES          = 8;
    localparam int MAX_STAGES          = 24;

    localparam int POS_LIMIT  = 4000000;
    localparam int TURN_SCALE = 683565276;

    localparam logic [LEN_W-1:0] RST_BASE_OFFSET = 20'd33000;
    localparam logic [LEN_W-1:0] RST_BASE_HEIGHT = 20'd147000;
    localparam logic [LEN_W-1:0] RST_UPPER_LINK  = 20'd155000;
    localparam logic [LEN_W-1:0] RST_FORE_LINK   = 20'd135000;
    localparam logic [LEN_W-1:0] RST_TOOL_LINK   = 20'd218000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_OFFSET = 3'd0,
        REG_BASE_HEIGHT = 3'd1,
        REG_UPPER_LINK  = 3'd2,
        REG_FORE_LINK   = 3'd3,
        REG_TOOL_LINK   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0] a1;
        logic [LEN_W-1:0] d1;
        logic [LEN_W-1:0] a2;
        logic [LEN_W-1:0] a3;
        logic [LEN_W-1:0] d5;
    } afk_lens_t;

    // phase 0: base, 1: shoulder, 2: shoulder+elbow, 3: shoulder+elbow+wrist
    typedef struct packed {
        logic [3:0][PHASE_W-1:0] phase;
        logic [3:0]              neg;
    } afk_item_t;

    function automatic logic signed [PHASE_W-1:0] cordic_atan(input int i);
        logic signed [PHASE_W-1:0] v;
        case (i)
            0:       v = 33'sd536870912;
            1:       v = 33'sd316933406;
            2:       v = 33'sd167458907;
            3:       v = 33'sd85004756;
            4:       v = 33'sd42667331;
            5:       v = 33'sd21354465;
            6:       v = 33'sd10679838;
            7:       v = 33'sd5340245;
            8:       v = 33'sd2670163;
            9:       v = 33'sd1335087;
            10:      v = 33'sd667544;
            11:      v = 33'sd333772;
            12:      v = 33'sd166886;
            13:      v = 33'sd83443;
            14:      v = 33'sd41722;
            15:      v = 33'sd20861;
            16:      v = 33'sd10430;
            17:      v = 33'sd5215;
            18:      v = 33'sd2608;
            19:      v = 33'sd1304;
            20:      v = 33'sd652;
            21:      v = 33'sd326;
            22:      v = 33'sd163;
            23:      v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [CS_W-1:0] cordic_gain(input int n);
        logic signed [CS_W-1:0] v;
        case (n)
            8:       v = 33'sd652039507;
            9:       v = 33'sd652034532;
            10:      v = 33'sd652033289;
            11:      v = 33'sd652032978;
            12:      v = 33'sd652032900;
            13:      v = 33'sd652032881;
            14:      v = 33'sd652032876;
            default: v = 33'sd652032874;
        endcase
        return v;
    endfunction

endpackage

FILE: design/afk_front.sv
// Front end: joint angle sums, scaling to binary phase and quadrant folding.
// Depends on afk_pkg.
module afk_front #(
    parameter int ANGLE_FRAC_BITS = afk_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [afk_pkg::ANG_W-1:0]     base_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]     shoulder_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]     elbow_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]     wrist_angle,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output afk_pkg::afk_item_t                   q_item
);
    import afk_pkg::*;

    localparam int SUM_W  = ANG_W + 2;
    localparam int PROD_W = SUM_W + 31;
    localparam int EXT_W  = PROD_W + ANGLE_FRAC_BITS + 1;
    localparam logic signed [30:0] TURN_S = 31'(TURN_SCALE);
    localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) <<< (ANGLE_FRAC_BITS - 1);
    localparam logic signed [PHASE_W-1:0] QUARTER = 33'sd1073741824;
    localparam logic signed [PHASE_W-1:0] HALF_TURN = 33'sd2147483648;

    logic signed [SUM_W-1:0]  sum_angle [4];
    logic signed [PROD_W-1:0] prod_reg  [4];
    logic                     valid_reg;

    assign sum_angle[0] = SUM_W'(base_angle);
    assign sum_angle[1] = SUM_W'(shoulder_angle);
    assign sum_angle[2] = SUM_W'(shoulder_angle) + SUM_W'(elbow_angle);
    assign sum_angle[3] = SUM_W'(shoulder_angle) + SUM_W'(elbow_angle)
                        + SUM_W'(wrist_angle);

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PROD_W'(sum_angle[k]) * PROD_W'(TURN_S);
            end
        end
    end

    always_comb
    begin
        logic signed [EXT_W-1:0]   rnd;
        logic signed [PHASE_W-1:0] z;
        q_item = '0;
        for (int k = 0; k < 4; k++)
        begin
            rnd = EXT_W'(prod_reg[k]) + HALF;
            z   = PHASE_W'($signed(rnd[ANGLE_FRAC_BITS +: 32]));
            if (z > QUARTER)
            begin
                q_item.phase[k] = z - HALF_TURN;
                q_item.neg[k]   = 1'b1;
            end
            else if (z < -QUARTER)
            begin
                q_item.phase[k] = z + HALF_TURN;
                q_item.neg[k]   = 1'b1;
            end
            else
            begin
                q_item.phase[k] = z;
                q_item.neg[k]   = 1'b0;
            end
        end
    end

endmodule

FILE: design/afk_queue.sv
// Short queue between front end and back end of the kinematics block.
// Depends on afk_pkg.
module afk_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  afk_pkg::afk_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output afk_pkg::afk_item_t out_item
);
    import afk_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    afk_item_t          mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != CNT_W'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");
`endif

endmodule

FILE: design/afk_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q30 of a folded phase.
// Depends on afk_pkg.
module afk_cordic #(
    parameter int STAGES = afk_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [afk_pkg::PHASE_W-1:0]   phase,
    input  logic                                 neg,
    output logic signed [afk_pkg::CS_W-1:0]      cos_out,
    output logic signed [afk_pkg::CS_W-1:0]      sin_out
);
    import afk_pkg::*;

    localparam int NCLAMP = (STAGES < MIN_STAGES) ? MIN_STAGES :
                            (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

    logic signed [CS_W-1:0]    x_reg [STAGES];
    logic signed [CS_W-1:0]    y_reg [STAGES];
    logic signed [PHASE_W-1:0] z_reg [STAGES];
    logic                      n_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [CS_W-1:0]    xi;
        logic signed [CS_W-1:0]    yi;
        logic signed [PHASE_W-1:0] zi;
        logic                      ni;

        if (i == 0)
        begin : g_first
            assign xi = cordic_gain(NCLAMP);
            assign yi = '0;
            assign zi = phase;
            assign ni = neg;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = n_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i] <= ni;
                if (zi >= 0)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - cordic_atan(i);
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + cordic_atan(i);
                end
            end
        end
    end

    assign cos_out = n_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
    assign sin_out = n_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];

endmodule

FILE: design/afk_back.sv
// Back end: four CORDIC pipelines, link length products, sums, rounding, saturation.
// Depends on afk_pkg and afk_cordic.
module afk_back #(
    parameter int CORDIC_STAGES = afk_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  afk_pkg::afk_item_t                  q_item,
    input  afk_pkg::afk_lens_t                  lens,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [afk_pkg::POS_W-1:0]    pos_x,
    output logic signed [afk_pkg::POS_W-1:0]    pos_y,
    output logic signed [afk_pkg::POS_W-1:0]    pos_z
);
    import afk_pkg::*;

    localparam int DEPTH = CORDIC_STAGES + 5;
    localparam int MUL_W = LEN_W + 1 + CS_W;
    localparam int ACC_W = MUL_W + 2;
    localparam int R10_W = ACC_W - 20;
    localparam int Z_W   = ACC_W - 30;
    localparam int XP_W  = R10_W + CS_W;
    localparam int XQ_W  = XP_W - 40;
    localparam logic signed [ACC_W-1:0] RND20 = ACC_W'(1) <<< 19;
    localparam logic signed [ACC_W-1:0] RND30 = ACC_W'(1) <<< 29;
    localparam logic signed [XP_W-1:0]  RND40 = XP_W'(1) <<< 39;

    logic [DEPTH-1:0]       vld_reg;
    logic                   en;
    logic signed [CS_W-1:0] cs_c [4];
    logic signed [CS_W-1:0] cs_s [4];

    logic signed [MUL_W-1:0] a2c2_reg, a3c23_reg, d5s235_reg;
    logic signed [MUL_W-1:0] a2s2_reg, a3s23_reg, d5c235_reg;
    logic signed [CS_W-1:0]  c1_p1_reg, s1_p1_reg, c1_p2_reg, s1_p2_reg;
    logic signed [CS_W-1:0]  c1_p3_reg, s1_p3_reg;
    logic signed [ACC_W-1:0] r30_reg, z30_reg;
    logic signed [R10_W-1:0] r10_reg;
    logic signed [Z_W-1:0]   zr_p3_reg, zr_p4_reg;
    logic signed [XP_W-1:0]  xp_reg, yp_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [ACC_W-1:0] r30_rnd, z30_rnd;
    logic signed [XP_W-1:0]  xp_rnd, yp_rnd;

    assign en        = !vld_reg[DEPTH-1] || out_ready;
    assign q_ready   = en;
    assign out_valid = vld_reg[DEPTH-1];
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;

    for (genvar k = 0; k < 4; k++)
    begin : g_cordic
        afk_cordic #(
            .STAGES (CORDIC_STAGES)
        ) u_cordic (
            .clk     (clk),
            .en      (en),
            .phase   ($signed(q_item.phase[k])),
            .neg     (q_item.neg[k]),
            .cos_out (cs_c[k]),
            .sin_out (cs_s[k])
        );
    end

    function automatic logic signed [POS_W-1:0] sat(input logic signed [XQ_W-1:0] v);
        if (v > XQ_W'(POS_LIMIT))
        begin
            return POS_W'(POS_LIMIT);
        end
        else if (v < -XQ_W'(POS_LIMIT))
        begin
            return -POS_W'(POS_LIMIT);
        end
        return v[POS_W-1:0];
    endfunction

    assign r30_rnd = r30_reg + RND20;
    assign z30_rnd = z30_reg + RND30;
    assign xp_rnd  = xp_reg + RND40;
    assign yp_rnd  = yp_reg + RND40;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2c2_reg   <= MUL_W'($signed({1'b0, lens.a2})) * MUL_W'(cs_c[1]);
            a3c23_reg  <= MUL_W'($signed({1'b0, lens.a3})) * MUL_W'(cs_c[2]);
            d5s235_reg <= MUL_W'($signed({1'b0, lens.d5})) * MUL_W'(cs_s[3]);
            a2s2_reg   <= MUL_W'($signed({1'b0, lens.a2})) * MUL_W'(cs_s[1]);
            a3s23_reg  <= MUL_W'($signed({1'b0, lens.a3})) * MUL_W'(cs_s[2]);
            d5c235_reg <= MUL_W'($signed({1'b0, lens.d5})) * MUL_W'(cs_c[3]);
            c1_p1_reg  <= cs_c[0];
            s1_p1_reg  <= cs_s[0];

            r30_reg <= ACC_W'($signed({1'b0, lens.a1, 30'b0})) + ACC_W'(a2c2_reg)
                     + ACC_W'(a3c23_reg) - ACC_W'(d5s235_reg);
            z30_reg <= ACC_W'($signed({1'b0, lens.d1, 30'b0})) - ACC_W'(a2s2_reg)
                     - ACC_W'(a3s23_reg) - ACC_W'(d5c235_reg);
            c1_p2_reg <= c1_p1_reg;
            s1_p2_reg <= s1_p1_reg;

            r10_reg   <= r30_rnd[ACC_W-1:20];
            zr_p3_reg <= z30_rnd[ACC_W-1:30];
            c1_p3_reg <= c1_p2_reg;
            s1_p3_reg <= s1_p2_reg;

            xp_reg    <= XP_W'(r10_reg) * XP_W'(c1_p3_reg);
            yp_reg    <= XP_W'(r10_reg) * XP_W'(s1_p3_reg);
            zr_p4_reg <= zr_p3_reg;

            pos_x_reg <= sat(xp_rnd[XP_W-1:40]);
            pos_y_reg <= sat(yp_rnd[XP_W-1:40]);
            pos_z_reg <= sat(XQ_W'(zr_p4_reg));
        end
    end

`ifndef SYNTHESIS
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(pos_x_reg) && $stable(pos_z_reg))
        else $error("result changed while stalled");
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_x_reg <= POS_W'(POS_LIMIT)) && (pos_x_reg >= -POS_W'(POS_LIMIT)))
        else $error("x beyond saturation limit");
`endif

endmodule

FILE: design/arm_forward_kinematics.sv
// Top level of the arm forward kinematics block: link length registers and wiring.
// Depends on afk_pkg, afk_front, afk_queue and afk_back.
//
// Usage:
//   Input channel in_valid/in_ready carries base, shoulder, elbow and wrist angles,
//   signed Q4.12 radians. Output channel out_valid/out_ready carries pos_x, pos_y,
//   pos_z in signed micrometres, saturated to +-4000000. One result per input.
//   Configuration channel cfg_valid/cfg_ready writes link length cfg_data into
//   register cfg_index (0 a1, 1 d1, 2 a2, 3 a3, 4 d5); other indexes are ignored.
//   cfg_ready is always high; write only while no item is in flight.
//   Throughput: one transfer per cycle on each channel while out_ready stays high.
//   Path from input transfer to out_valid: front stage, queue, CORDIC pipeline,
//   then the product, sum, rounding, output product and saturation stages.
//   Reset clears all pipeline and queue control and loads the default lengths.
//   A receiver stall freezes the back pipeline; the two-entry queue and the
//   front stage keep taking items until they fill, then in_ready drops.
module arm_forward_kinematics #(
    parameter int ANGLE_FRAC_BITS = afk_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = afk_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [afk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [afk_pkg::LEN_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [afk_pkg::ANG_W-1:0]     base_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]     shoulder_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]     elbow_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]     wrist_angle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [afk_pkg::POS_W-1:0]     pos_x,
    output logic signed [afk_pkg::POS_W-1:0]     pos_y,
    output logic signed [afk_pkg::POS_W-1:0]     pos_z
);
    import afk_pkg::*;

    afk_lens_t lens_reg;
    logic      fq_valid;
    logic      fq_ready;
    afk_item_t fq_item;
    logic      qb_valid;
    logic      qb_ready;
    afk_item_t qb_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lens_reg.a1 <= RST_BASE_OFFSET;
            lens_reg.d1 <= RST_BASE_HEIGHT;
            lens_reg.a2 <= RST_UPPER_LINK;
            lens_reg.a3 <= RST_FORE_LINK;
            lens_reg.d5 <= RST_TOOL_LINK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_OFFSET: lens_reg.a1 <= cfg_data;
                REG_BASE_HEIGHT: lens_reg.d1 <= cfg_data;
                REG_UPPER_LINK:  lens_reg.a2 <= cfg_data;
                REG_FORE_LINK:   lens_reg.a3 <= cfg_data;
                REG_TOOL_LINK:   lens_reg.d5 <= cfg_data;
                default:         ;
            endcase
        end
    end

    afk_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_angle     (base_angle),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .wrist_angle    (wrist_angle),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_item         (fq_item)
    );

    afk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    afk_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .lens      (lens_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z)
    );

endmodule

FILE: test/tb_arm_forward_kinematics.sv
// Self-checking testbench of arm_forward_kinematics: CORDIC position predictor,
// random idling on both channels and link length sweeps. Depends on afk_pkg and arm_forward_kinematics.
`timescale 1ns / 1ps
module tb_arm_forward_kinematics;
    import afk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = DEF_CORDIC_STAGES + 12;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic signed [ANG_W-1:0] base;
        logic signed [ANG_W-1:0] shoulder;
        logic signed [ANG_W-1:0] elbow;
        logic signed [ANG_W-1:0] wrist;
    } joints_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } tool_pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [ANG_W-1:0] base_angle = '0;
    logic signed [ANG_W-1:0] shoulder_angle = '0;
    logic signed [ANG_W-1:0] elbow_angle = '0;
    logic signed [ANG_W-1:0] wrist_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    joints_t   joint_queue[$];
    tool_pos_t pos_queue[$];
    logic [LEN_W-1:0] link_len [5];
    int send_idle_pct = 11;
    int recv_idle_pct = 45;
    int test_phase = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int quiet_cycles = 0;

    arm_forward_kinematics i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .base_angle(base_angle), .shoulder_angle(shoulder_angle),
        .elbow_angle(elbow_angle), .wrist_angle(wrist_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void cordic_sin_cos(input longint angle, output longint c_q30,
                                           output longint s_q30);
        longint ph;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        ph = (angle * TURN_SCALE + (64'sd1 <<< (DEF_ANGLE_FRAC_BITS - 1)))
             >>> DEF_ANGLE_FRAC_BITS;
        z = longint'($signed(ph[31:0]));
        flip = 1'b0;
        if (z > (64'sd1 <<< 30))
        begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        x = longint'(cordic_gain(DEF_CORDIC_STAGES));
        y = 0;
        for (int i = 0; i < DEF_CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(cordic_atan(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(cordic_atan(i));
            end
        end
        c_q30 = flip ? -x : x;
        s_q30 = flip ? -y : y;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > longint'(POS_LIMIT))
            v = longint'(POS_LIMIT);
        if (v < -longint'(POS_LIMIT))
            v = -longint'(POS_LIMIT);
        return v[POS_W-1:0];
    endfunction

    function automatic tool_pos_t tool_position(input joints_t j);
        longint b, s, e, w;
        longint c1, s1, c2, s2, c23, s23, c235, s235;
        longint r30, r10, z30;
        tool_pos_t p;
        b = longint'(j.base);
        s = longint'(j.shoulder);
        e = longint'(j.elbow);
        w = longint'(j.wrist);
        cordic_sin_cos(b, c1, s1);
        cordic_sin_cos(s, c2, s2);
        cordic_sin_cos(s + e, c23, s23);
        cordic_sin_cos(s + e + w, c235, s235);
        r30 = (longint'(link_len[REG_BASE_OFFSET]) <<< 30)
            + longint'(link_len[REG_UPPER_LINK]) * c2
            + longint'(link_len[REG_FORE_LINK]) * c23
            - longint'(link_len[REG_TOOL_LINK]) * s235;
        r10 = (r30 + (64'sd1 <<< 19)) >>> 20;
        z30 = (longint'(link_len[REG_BASE_HEIGHT]) <<< 30)
            - longint'(link_len[REG_UPPER_LINK]) * s2
            - longint'(link_len[REG_FORE_LINK]) * s23
            - longint'(link_len[REG_TOOL_LINK]) * c235;
        p.x = clamp_pos((r10 * c1 + (64'sd1 <<< 39)) >>> 40);
        p.y = clamp_pos((r10 * s1 + (64'sd1 <<< 39)) >>> 40);
        p.z = clamp_pos((z30 + (64'sd1 <<< 29)) >>> 30);
        return p;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", field, got, want, checked);
        errors++;
    endtask

    // driver: predict on each transfer, then offer the next pending item
    always @(posedge clk)
    begin
        joints_t j;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                j.base = base_angle;
                j.shoulder = shoulder_angle;
                j.elbow = elbow_angle;
                j.wrist = wrist_angle;
                pos_queue.push_back(tool_position(j));
                sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (joint_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    j = joint_queue.pop_front();
                    in_valid <= 1'b1;
                    base_angle <= j.base;
                    shoulder_angle <= j.shoulder;
                    elbow_angle <= j.elbow;
                    wrist_angle <= j.wrist;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off in the last phase
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (test_phase == 4 && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tool_pos_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pos_queue.size() == 0)
            begin
                $display("UNEXPECTED result: x %0d y %0d z %0d", pos_x, pos_y, pos_z);
                errors++;
            end
            else
            begin
                want = pos_queue.pop_front();
                if (pos_x !== want.x)
                    report_mismatch("pos_x", longint'(pos_x), longint'(want.x));
                if (pos_y !== want.y)
                    report_mismatch("pos_y", longint'(pos_y), longint'(want.y));
                if (pos_z !== want.z)
                    report_mismatch("pos_z", longint'(pos_z), longint'(want.z));
                checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_len(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_TOOL_LINK)
            link_len[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_lens(input logic [LEN_W-1:0] a1, input logic [LEN_W-1:0] d1,
                                  input logic [LEN_W-1:0] a2, input logic [LEN_W-1:0] a3,
                                  input logic [LEN_W-1:0] d5);
        write_len(REG_BASE_OFFSET, a1);
        write_len(REG_BASE_HEIGHT, d1);
        write_len(REG_UPPER_LINK, a2);
        write_len(REG_FORE_LINK, a3);
        write_len(REG_TOOL_LINK, d5);
    endtask

    task automatic wait_drained();
        while (joint_queue.size() > 0 || in_valid || pos_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_joints(input int b, input int s, input int e, input int w);
        joints_t j;
        j.base = ANG_W'(b);
        j.shoulder = ANG_W'(s);
        j.elbow = ANG_W'(e);
        j.wrist = ANG_W'(w);
        joint_queue.push_back(j);
    endtask

    task automatic add_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                add_joints($urandom_range(0, 25736) - 12868, $urandom_range(0, 25736) - 12868,
                           $urandom_range(0, 25736) - 12868, $urandom_range(0, 25736) - 12868);
            else
                add_joints($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        link_len[REG_BASE_OFFSET] = RST_BASE_OFFSET;
        link_len[REG_BASE_HEIGHT] = RST_BASE_HEIGHT;
        link_len[REG_UPPER_LINK] = RST_UPPER_LINK;
        link_len[REG_FORE_LINK] = RST_FORE_LINK;
        link_len[REG_TOOL_LINK] = RST_TOOL_LINK;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero, quarter and half turns, extremes, beyond one turn
        add_joints(0, 0, 0, 0);
        add_joints(6434, 0, 0, 0);
        add_joints(-6434, 6434, 0, 0);
        add_joints(12868, 0, 6434, 0);
        add_joints(-12868, 0, 0, 6434);
        add_joints(0, -6434, -6434, -6434);
        add_joints(32767, 32767, 32767, 32767);
        add_joints(-32768, -32768, -32768, -32768);
        add_joints(32767, -32768, 32767, -32768);
        add_joints(25736, 25736, 0, 0);
        add_joints(30000, 12868, 12868, 12868);
        add_joints(1, -1, 1, -1);
        add_joints(3217, 3217, 3217, 3217);
        add_joints(-3217, 9651, -9651, 19302);
        add_joints(16384, -16384, 8192, -8192);
        add_joints(6433, 6435, -6433, -6435);
        wait_drained();

        test_phase = 1;
        write_all_lens('0, '0, '0, '0, '0);
        add_joints(6434, 6434, 6434, 6434);
        add_random(100);
        wait_drained();

        // largest lengths; some positions reach saturation
        test_phase = 2;
        write_all_lens('1, '1, '1, '1, '1);
        add_joints(0, 0, 0, 0);
        add_joints(0, 12868, 0, 0);
        add_joints(6434, -6434, 0, 0);
        add_random(200);
        wait_drained();

        test_phase = 3;
        send_idle_pct = 45;
        recv_idle_pct = 11;
        for (int k = REG_TOOL_LINK + 1; k < (1 << CFG_IDX_W); k++)
            write_len(CFG_IDX_W'(k), LEN_W'($urandom));
        write_all_lens(LEN_W'($urandom_range(0, 1000000)), LEN_W'($urandom_range(0, 1000000)),
                       LEN_W'($urandom_range(0, 1000000)), LEN_W'($urandom_range(0, 1000000)),
                       LEN_W'($urandom_range(0, 1000000)));
        add_random(600);
        wait_drained();

        test_phase = 4;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_lens(RST_BASE_OFFSET, RST_BASE_HEIGHT, RST_UPPER_LINK,
                       RST_FORE_LINK, RST_TOOL_LINK);
        add_random(650);
        wait_drained();

        $display("Sent %0d joint sets and checked %0d positions over five link settings,",
                 sent, checked);
        $display("including zero and full-scale lengths and ignored register writes.");
        if (errors == 0 && pos_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
